// ===== sv/vmdb_pkg.sv =====
`default_nettype none

package vmdb_pkg;

  // default sizes of the volume and the colour channels
  localparam int MAX_DIM_LOG2_DEF = 8;
  localparam int CHANNEL_BITS_DEF = 8;

  // configuration word widths
  localparam int LOG2_W    = 4;
  localparam int CFG_IDX_W = 2;

  // each channel sum carries three extra bits for the eight weights of a block
  localparam int SUM_GROWTH = 3;
  localparam int NUM_CHAN   = 4;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH_LOG2  = 2'd0,
    REG_HEIGHT_LOG2 = 2'd1,
    REG_DEPTH_LOG2  = 2'd2
  } cfg_reg_t;

endpackage

`default_nettype wire

// ===== sv/vmdb_plane_store.sv =====
`default_nettype none

module vmdb_plane_store #(
  parameter int IDX_W   = 2 * (vmdb_pkg::MAX_DIM_LOG2_DEF - 1),
  parameter int ENTRY_W = vmdb_pkg::NUM_CHAN
                          * (vmdb_pkg::CHANNEL_BITS_DEF + vmdb_pkg::SUM_GROWTH)
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               rd_en,
  input  wire logic [IDX_W-1:0]   rd_idx,
  input  wire logic               wr_en,
  input  wire logic [IDX_W-1:0]   wr_idx,
  input  wire logic [ENTRY_W-1:0] wr_data,
  output logic      [ENTRY_W-1:0] rd_data
);

  localparam int ENTRIES = 1 << IDX_W;

  logic [ENTRY_W-1:0] mem [ENTRIES];
  logic [ENTRY_W-1:0] rd_raw_r;
  logic               fwd_r;
  logic [ENTRY_W-1:0] fwd_data_r;

  // single-port-write, single-port-read sum store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      rd_raw_r <= mem[rd_idx];
    end
  end

  // a write landing on the entry being read in the same cycle is bypassed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_idx == rd_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      fwd_data_r <= wr_data;
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_raw_r;

endmodule

`default_nettype wire

// ===== sv/volume_mip_downsample_box_core.sv =====
`default_nettype none

// 2x2x2 box-filter mip reduction of a volume level. Source texels arrive in
// raster order (x fastest, then y, then z) and each next-level texel, the
// floor of the mean of its 2x2x2 block, leaves on the word that completes
// its block; out_last_texel marks the final texel of the level. Throughput
// is one source texel per cycle: each word does one read-modify-write of a
// plane-sum memory entry (registered read, then add and write back), with
// a bypass when consecutive words hit the same entry. Input is held off
// only while a finished texel waits in the output register and the word
// in stage 1 would produce another. The sum memory needs
// no clearing after reset: the first texel of a block overwrites its entry.
// An axis of size one counts its single texel twice. Writing any
// configuration register restarts the level; write only when idle.
module volume_mip_downsample_box_core #(
  parameter int MAX_DIM_LOG2 = vmdb_pkg::MAX_DIM_LOG2_DEF,
  parameter int CHANNEL_BITS = vmdb_pkg::CHANNEL_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,

  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [vmdb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [vmdb_pkg::LOG2_W-1:0]    cfg_data,

  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [CHANNEL_BITS-1:0]        in_red,
  input  wire logic [CHANNEL_BITS-1:0]        in_green,
  input  wire logic [CHANNEL_BITS-1:0]        in_blue,
  input  wire logic [CHANNEL_BITS-1:0]        in_alpha,

  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [CHANNEL_BITS-1:0]        out_red,
  output logic      [CHANNEL_BITS-1:0]        out_green,
  output logic      [CHANNEL_BITS-1:0]        out_blue,
  output logic      [CHANNEL_BITS-1:0]        out_alpha,
  output logic                                out_last_texel
);

  localparam int LW      = vmdb_pkg::LOG2_W;
  localparam int NC      = vmdb_pkg::NUM_CHAN;
  localparam int SUM_W   = CHANNEL_BITS + vmdb_pkg::SUM_GROWTH;
  localparam int ENTRY_W = NC * SUM_W;
  localparam int IDX_W   = (MAX_DIM_LOG2 > 1) ? 2 * (MAX_DIM_LOG2 - 1) : 1;
  localparam int POS_W   = MAX_DIM_LOG2;
  localparam int TMP_W   = 2 * MAX_DIM_LOG2;
  localparam logic [LW-1:0] MAX_L2   = LW'(MAX_DIM_LOG2);
  localparam logic [LW-1:0] RESET_L2 = (MAX_DIM_LOG2 < 8) ? MAX_L2 : LW'(8);

  typedef logic [NC-1:0][SUM_W-1:0] sums_t;

  // configuration
  logic [LW-1:0] wl_r, hl_r, dl_r;
  logic [LW-1:0] cfg_clamped;
  logic          cfg_acc;
  logic          cfg_known;

  // raster position of the next word
  logic [POS_W-1:0] x_r, y_r, z_r;
  logic [POS_W-1:0] x_nxt, y_nxt, z_nxt;

  // stage 1: item waiting for its read data
  logic             s1_valid_r;
  logic [IDX_W-1:0] s1_idx_r;
  sums_t            s1_v_r;
  logic             s1_first_r, s1_last_r, s1_final_r;
  logic             s1_fire;

  // output register
  logic                    out_valid_r;
  logic [CHANNEL_BITS-1:0] out_red_r, out_green_r, out_blue_r, out_alpha_r;
  logic                    out_last_r;
  logic                    out_free;

  logic             in_acc;
  logic [1:0]       dup_shift;
  sums_t            in_v;
  logic [IDX_W-1:0] in_idx;
  logic [TMP_W-1:0] idx_tmp;
  logic [LW-1:0]    row_shift;
  logic [POS_W:0]   w_end_full, h_end_full, d_end_full;
  logic             x_end, y_end, z_end;
  logic             in_first, in_last;
  logic [ENTRY_W-1:0] rd_data;
  sums_t            old_sums, new_sums;

  assign cfg_ready   = 1'b1;
  assign cfg_acc     = cfg_valid && cfg_ready;
  assign cfg_clamped = (cfg_data > MAX_L2) ? MAX_L2 : cfg_data;

  // only a mapped index restarts the level
  always_comb begin
    case (vmdb_pkg::cfg_reg_t'(cfg_index))
      vmdb_pkg::REG_WIDTH_LOG2,
      vmdb_pkg::REG_HEIGHT_LOG2,
      vmdb_pkg::REG_DEPTH_LOG2: cfg_known = 1'b1;
      default:                  cfg_known = 1'b0;
    endcase
  end

  // register writes; an unknown index is ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wl_r <= RESET_L2;
      hl_r <= RESET_L2;
      dl_r <= RESET_L2;
    end else if (cfg_acc) begin
      case (vmdb_pkg::cfg_reg_t'(cfg_index))
        vmdb_pkg::REG_WIDTH_LOG2:  wl_r <= cfg_clamped;
        vmdb_pkg::REG_HEIGHT_LOG2: hl_r <= cfg_clamped;
        vmdb_pkg::REG_DEPTH_LOG2:  dl_r <= cfg_clamped;
        default: ;
      endcase
    end
  end

  // handshake
  assign out_free = !out_valid_r || out_ready;
  assign s1_fire  = s1_valid_r && (!s1_last_r || out_free);
  assign in_ready = !s1_valid_r || s1_fire;
  assign in_acc   = in_valid && in_ready;

  // axis ends
  assign w_end_full = ((POS_W + 1)'(1) << wl_r) - (POS_W + 1)'(1);
  assign h_end_full = ((POS_W + 1)'(1) << hl_r) - (POS_W + 1)'(1);
  assign d_end_full = ((POS_W + 1)'(1) << dl_r) - (POS_W + 1)'(1);
  assign x_end = (x_r == w_end_full[POS_W-1:0]);
  assign y_end = (y_r == h_end_full[POS_W-1:0]);
  assign z_end = (z_r == d_end_full[POS_W-1:0]);

  // block position flags
  assign in_first = !x_r[0] && !y_r[0] && !z_r[0];
  assign in_last  = ((wl_r == '0) || x_r[0])
                 && ((hl_r == '0) || y_r[0])
                 && ((dl_r == '0) || z_r[0]);

  // plane entry: (y/2) * next width + x/2, next width a power of two
  assign row_shift = (wl_r == '0) ? '0 : wl_r - LW'(1);
  assign idx_tmp   = (TMP_W'(y_r >> 1) << row_shift) | TMP_W'(x_r >> 1);
  assign in_idx    = idx_tmp[IDX_W-1:0];

  // weight: doubled once per axis of size one
  assign dup_shift = 2'(wl_r == '0) + 2'(hl_r == '0) + 2'(dl_r == '0);
  assign in_v[0]   = SUM_W'(in_red)   << dup_shift;
  assign in_v[1]   = SUM_W'(in_green) << dup_shift;
  assign in_v[2]   = SUM_W'(in_blue)  << dup_shift;
  assign in_v[3]   = SUM_W'(in_alpha) << dup_shift;

  // raster advance with wrap at each axis end
  always_comb begin
    x_nxt = x_r + POS_W'(1);
    y_nxt = y_r;
    z_nxt = z_r;
    if (x_end) begin
      x_nxt = '0;
      y_nxt = y_r + POS_W'(1);
      if (y_end) begin
        y_nxt = '0;
        z_nxt = z_end ? '0 : z_r + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r <= '0;
      y_r <= '0;
      z_r <= '0;
    end else if (cfg_acc && cfg_known) begin
      x_r <= '0;
      y_r <= '0;
      z_r <= '0;
    end else if (in_acc) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  // stage 1 control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_idx_r   <= in_idx;
      s1_v_r     <= in_v;
      s1_first_r <= in_first;
      s1_last_r  <= in_last;
      s1_final_r <= x_end && y_end && z_end;
    end
  end

  // plane sum store
  vmdb_plane_store #(
    .IDX_W   (IDX_W),
    .ENTRY_W (ENTRY_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_acc),
    .rd_idx  (in_idx),
    .wr_en   (s1_fire),
    .wr_idx  (s1_idx_r),
    .wr_data (new_sums),
    .rd_data (rd_data)
  );

  // accumulate; the block's first word overwrites the entry
  assign old_sums = rd_data;
  always_comb begin
    for (int c = 0; c < NC; c++) begin
      new_sums[c] = s1_first_r ? s1_v_r[c] : old_sums[c] + s1_v_r[c];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_last_r) begin
      out_red_r   <= new_sums[0][SUM_W-1:3];
      out_green_r <= new_sums[1][SUM_W-1:3];
      out_blue_r  <= new_sums[2][SUM_W-1:3];
      out_alpha_r <= new_sums[3][SUM_W-1:3];
      out_last_r  <= s1_final_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_red_r;
  assign out_green      = out_green_r;
  assign out_blue       = out_blue_r;
  assign out_alpha      = out_alpha_r;
  assign out_last_texel = out_last_r;

endmodule

`default_nettype wire
